// File: hdl/mcfr_pkg.sv
// ----------------------------------------------------------------------------
// mcfr_pkg
// Shared types and constants of the mailbox command framer and responder.
// ----------------------------------------------------------------------------
package mcfr_pkg;

  localparam int unsigned MAX_WORDS_DEFAULT = 32;

  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [7:0]  CMD_STATE  = 8'hB2;
  localparam logic [7:0]  CMD_FUSE   = 8'h97;
  localparam logic [7:0]  CMD_FWVER  = 8'h9D;
  localparam logic [7:0]  CMD_RANDOM = 8'hCD;
  localparam logic [7:0]  RESP_TAG   = 8'hE1;
  localparam logic [31:0] STATUS_OK  = 32'h0000_00D6;

  localparam logic [7:0]  INFO_CMD_RESET   = 8'd218;
  localparam logic [31:0] FW_VERSION_RESET = 32'h0001_0000;
  localparam logic [31:0] MEM_STATE_RESET  = 32'h0000_00CA;

  typedef enum logic [1:0] {
    REG_INFO_CMD  = 2'd0,
    REG_FW_VER    = 2'd1,
    REG_MEM_STATE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    RIDX_HEADER = 2'd0,
    RIDX_STATUS = 2'd1,
    RIDX_EXTRA  = 2'd2,
    RIDX_TAIL   = 2'd3
  } resp_idx_t;

  typedef struct packed {
    logic [7:0]  info_command_code;
    logic [31:0] firmware_version_word;
    logic [31:0] memory_state_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  last_index;
    logic [31:0] header;
    logic [31:0] extra;
  } resp_desc_t;

endpackage

// File: hdl/mcfr_if.sv
// ----------------------------------------------------------------------------
// mcfr_if
// Valid/ready channels for mailbox words and response-register writes.
// ----------------------------------------------------------------------------
interface mcfr_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] mailbox_word;

  modport source (output valid, output mailbox_word, input ready);
  modport sink (input valid, input mailbox_word, output ready);
endinterface

interface mcfr_resp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  response_index;
  logic [31:0] response_value;
  logic        last_word;

  modport source (output valid, output response_index, output response_value,
                  output last_word, input ready);
  modport sink (input valid, input response_index, input response_value,
                input last_word, output ready);
endinterface

// File: hdl/mcfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// mcfr_cfg_regs
// APB-style configuration registers: info command code, firmware version
// word and memory state code.
// ----------------------------------------------------------------------------
module mcfr_cfg_regs import mcfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic     wr_en;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.info_command_code     <= INFO_CMD_RESET;
      cfg.firmware_version_word <= FW_VERSION_RESET;
      cfg.memory_state_code     <= MEM_STATE_RESET;
    end else if (wr_en) begin
      case (sel)
        REG_INFO_CMD:  cfg.info_command_code     <= pwdata[7:0];
        REG_FW_VER:    cfg.firmware_version_word <= pwdata;
        REG_MEM_STATE: cfg.memory_state_code     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_INFO_CMD:  prdata = {24'd0, cfg.info_command_code};
      REG_FW_VER:    prdata = cfg.firmware_version_word;
      REG_MEM_STATE: prdata = cfg.memory_state_code;
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// File: hdl/mcfr_framer.sv
// ----------------------------------------------------------------------------
// mcfr_framer
// Counts mailbox words against the header size and, on completion, builds
// the descriptor of the canned response.
// ----------------------------------------------------------------------------
module mcfr_framer import mcfr_pkg::*; #(
  parameter int unsigned MAX_WORDS = MAX_WORDS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  mcfr_word_if.sink  mbox,
  input  cfg_t       cfg,
  output logic       desc_valid,
  input  logic       desc_ready,
  output resp_desc_t desc
);

  localparam int unsigned CW = $clog2(MAX_WORDS + 1);
  localparam logic [8:0]  MAX_W9 = 9'(MAX_WORDS);

  logic [CW-1:0] words_received, words_received_next;
  logic [7:0]    expected_words, expected_words_next;
  logic [7:0]    header_version, header_version_next;
  logic [7:0]    header_command, header_command_next;

  logic          accept;
  logic          overflow;
  logic          bad_size;
  logic          complete;
  logic          respond;
  logic [CW-1:0] count;
  logic [7:0]    size;

  assign mbox.ready = desc_ready;
  assign accept     = mbox.valid && desc_ready;
  assign overflow   = 9'(words_received) >= MAX_W9;
  assign count      = words_received + CW'(1);

  always_comb begin
    header_version_next = header_version;
    header_command_next = header_command;
    expected_words_next = expected_words;
    bad_size            = 1'b0;
    if (words_received == '0) begin
      header_version_next = mbox.mailbox_word[7:0];
      expected_words_next = mbox.mailbox_word[15:8];
      header_command_next = mbox.mailbox_word[23:16];
      bad_size = (mbox.mailbox_word[15:8] == 8'd0) ||
                 (9'(mbox.mailbox_word[15:8]) > MAX_W9);
    end
    complete = !overflow && !bad_size && (9'(count) == 9'(expected_words_next));

    words_received_next = count;
    if (overflow || bad_size || complete) begin
      words_received_next = '0;
      expected_words_next = 8'd0;
    end
  end

  always_comb begin
    respond    = complete;
    size       = 8'd2;
    desc.extra = 32'd0;
    priority if (header_command_next == cfg.info_command_code) begin
      respond = complete && (9'(count) >= 9'd4);
    end else if (header_command_next == CMD_STATE) begin
      size       = 8'd4;
      desc.extra = cfg.memory_state_code;
    end else if (header_command_next == CMD_FUSE) begin
      size = 8'd3;
    end else if (header_command_next == CMD_FWVER) begin
      size       = 8'd4;
      desc.extra = cfg.firmware_version_word;
    end else begin
      size = 8'd2;
    end
    desc.last_index = size[1:0] - 2'd1;
    desc.header     = {RESP_TAG, header_command_next, size, header_version_next};
  end

  assign desc_valid = accept && respond;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_received <= '0;
      expected_words <= 8'd0;
      header_version <= 8'd0;
      header_command <= 8'd0;
    end else if (accept) begin
      words_received <= words_received_next;
      expected_words <= expected_words_next;
      if (!overflow) begin
        header_version <= header_version_next;
        header_command <= header_command_next;
      end
    end
  end

endmodule

// File: hdl/mcfr_emitter.sv
// ----------------------------------------------------------------------------
// mcfr_emitter
// Plays response descriptors out as indexed register beats, with one more
// descriptor held in a spare slot behind the one being sent.
// ----------------------------------------------------------------------------
module mcfr_emitter import mcfr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         desc_valid,
  output logic         desc_ready,
  input  resp_desc_t   desc,
  mcfr_resp_if.source  response
);

  logic       busy;
  resp_idx_t  idx;
  resp_desc_t held;
  logic       spare_valid;
  resp_desc_t spare;
  logic       beat;
  logic       finish;
  logic       take;

  assign beat       = busy && response.ready;
  assign finish     = beat && (idx == resp_idx_t'(held.last_index));
  assign desc_ready = !spare_valid;
  assign take       = desc_valid && desc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      idx         <= RIDX_HEADER;
      spare_valid <= 1'b0;
    end else if (!busy || finish) begin
      busy        <= take || spare_valid;
      idx         <= RIDX_HEADER;
      spare_valid <= 1'b0;
    end else begin
      if (beat) begin
        idx <= resp_idx_t'(idx + 2'd1);
      end
      if (take) begin
        spare_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((!busy || finish) && (take || spare_valid)) begin
      held <= spare_valid ? spare : desc;
    end
    if (busy && !finish && take) begin
      spare <= desc;
    end
  end

  assign response.valid          = busy;
  assign response.response_index = idx;
  assign response.last_word      = (idx == resp_idx_t'(held.last_index));

  always_comb begin
    unique case (idx)
      RIDX_HEADER: response.response_value = held.header;
      RIDX_STATUS: response.response_value = STATUS_OK;
      RIDX_EXTRA:  response.response_value = held.extra;
      RIDX_TAIL:   response.response_value = 32'd0;
    endcase
  end

endmodule

// File: hdl/mailbox_command_framer_responder_unit.sv
// ----------------------------------------------------------------------------
// mailbox_command_framer_responder_unit
// Mailbox command framer with canned response-register writes.
//
// The mailbox channel takes one 32-bit word per beat; the first word of a
// message is the header (version, size, command, tag), later words are
// counted. When size words have arrived, the response channel carries the
// answer as indexed register beats: header, status, then the command's
// extra word (zero if none) and a zero tail as the size allows, with
// last_word on the final beat. Headers with a size of zero or above
// MAX_WORDS, and info commands under four words, get no response. With
// an idle response side, responses start in the next cycle. A finished
// response waits in a one-deep slot while the one before it is still being
// sent; the mailbox channel takes a word every cycle while that slot is
// empty and stalls only while it is full.
// If the receiver stalls, the current beat holds, the slot fills behind it
// and the mailbox channel stalls. Reset clears the framer and the response
// stage and loads the configuration registers with their defaults; the block
// is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module mailbox_command_framer_responder_unit import mcfr_pkg::*; #(
  parameter int unsigned MAX_WORDS = MAX_WORDS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  mcfr_word_if.sink             mbox,
  mcfr_resp_if.source           response,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t       cfg;
  resp_desc_t desc;
  logic       desc_valid;
  logic       desc_ready;

  mcfr_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcfr_framer #(
    .MAX_WORDS (MAX_WORDS)
  ) u_framer (
    .clk        (clk),
    .rst        (rst),
    .mbox       (mbox),
    .cfg        (cfg),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  mcfr_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .response   (response)
  );

endmodule
